### design/cwa_pkg.sv
`default_nettype none
package cwa_pkg;

  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned MAX_RADIUS  = 15;
  localparam int unsigned RAD_BITS    = 4;
  localparam int unsigned RING_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int unsigned WIN_BITS    = $clog2(RING_DEPTH + 1);
  localparam int unsigned SLOT_BITS   = $clog2(RING_DEPTH);
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int unsigned REM_BITS    = WIN_BITS + 1;
  localparam int unsigned STEP_BITS   = $clog2(SUM_BITS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  typedef struct packed {
    sum_t                sum;
    logic                has_main;
    logic                full_win;
    logic [RAD_BITS-1:0] flush;
    logic                eos;
    logic [WIN_BITS-1:0] wsize;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MAIN,
    BK_FLUSH
  } bk_state_e;

endpackage
`default_nettype wire

### design/cwa_front.sv
`default_nettype none
module cwa_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [cwa_pkg::RAD_BITS-1:0] cfg_radius_i,
  input  logic                         take_i,
  input  cwa_pkg::sample_t             sample_i,
  input  logic                         end_of_stream_i,
  output logic                         cmd_push_o,
  output cwa_pkg::cmd_t                cmd_o
);
  import cwa_pkg::*;

  logic [RAD_BITS-1:0]  radius_q;
  sum_t                 sum_q, sum_d;
  logic [WIN_BITS-1:0]  seen_q, seen_d;
  logic [SLOT_BITS-1:0] slot_q, slot_d;
  sample_t              ring_q [RING_DEPTH];

  logic [WIN_BITS-1:0]  wsize;
  logic [SLOT_BITS-1:0] slot;
  logic [WIN_BITS-1:0]  seen_new;
  sum_t                 old_val;
  sum_t                 sum_new;
  logic                 has_main;

  assign wsize    = {radius_q, 1'b1};
  assign slot     = ({1'b0, slot_q} < wsize) ? slot_q : '0;
  assign seen_new = (seen_q < wsize) ? seen_q + 1'b1 : seen_q;
  assign old_val  = (seen_q >= wsize) ? sum_t'(ring_q[slot]) : '0;
  assign sum_new  = sum_q - old_val + sum_t'(sample_i);
  assign has_main = seen_new > WIN_BITS'(radius_q);

  always_comb begin
    sum_d  = sum_q;
    seen_d = seen_q;
    slot_d = slot_q;
    if (cfg_valid_i || (take_i && end_of_stream_i)) begin
      sum_d  = '0;
      seen_d = '0;
      slot_d = '0;
    end else if (take_i) begin
      sum_d  = sum_new;
      seen_d = seen_new;
      slot_d = ({1'b0, slot} + 1'b1 >= wsize) ? '0 : slot + 1'b1;
    end
  end

  always_comb begin
    cmd_o.sum      = sum_new;
    cmd_o.has_main = has_main;
    cmd_o.full_win = seen_new >= wsize;
    cmd_o.eos      = end_of_stream_i;
    cmd_o.wsize    = wsize;
    if (!end_of_stream_i) begin
      cmd_o.flush = '0;
    end else if (has_main) begin
      cmd_o.flush = radius_q;
    end else begin
      cmd_o.flush = seen_new[RAD_BITS-1:0];
    end
  end

  assign cmd_push_o = take_i && (has_main || end_of_stream_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      sum_q    <= '0;
      seen_q   <= '0;
      slot_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        radius_q <= cfg_radius_i;
      end
      sum_q  <= sum_d;
      seen_q <= seen_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      ring_q[slot] <= sample_i;
    end
  end

endmodule
`default_nettype wire

### design/cwa_queue.sv
`default_nettype none
module cwa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cwa_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output cwa_pkg::cmd_t data_o
);
  import cwa_pkg::*;

  cmd_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QPTR_BITS:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### design/cwa_back.sv
`default_nettype none
module cwa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  cwa_pkg::cmd_t    cmd_i,
  output logic             q_pop_o,
  input  logic             pop,
  output logic             empty,
  output cwa_pkg::sample_t average_o,
  output logic             has_window_o,
  output logic             last_result_o
);
  import cwa_pkg::*;

  bk_state_e            state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [SUM_BITS-1:0]  mag_q, mag_d;
  logic [REM_BITS-1:0]  rem_q, rem_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 neg_q, neg_d;
  logic                 ov_q, ov_d;
  sample_t              avg_q, avg_d;
  logic                 hw_q, hw_d;
  logic                 last_q, last_d;

  logic                 slot_free;
  logic [REM_BITS-1:0]  trial;
  logic                 fit;
  logic [SUM_BITS-1:0]  quot;

  assign slot_free = !ov_q || pop;
  assign trial     = {rem_q[REM_BITS-2:0], mag_q[SUM_BITS-1]};
  assign fit       = trial >= REM_BITS'(cmd_q.wsize);
  assign quot      = neg_q ? -mag_q : mag_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (cmd_i.has_main && cmd_i.full_win) begin
            state_d = BK_DIV;
          end else if (cmd_i.has_main) begin
            state_d = BK_MAIN;
          end else begin
            state_d = BK_FLUSH;
          end
        end
      end
      BK_DIV: begin
        if (step_q == STEP_BITS'(SUM_BITS - 1)) begin
          state_d = BK_MAIN;
        end
      end
      BK_MAIN: begin
        if (slot_free) begin
          state_d = (cmd_q.flush != '0) ? BK_FLUSH : BK_IDLE;
        end
      end
      BK_FLUSH: begin
        if (slot_free && cmd_q.flush == RAD_BITS'(1)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_d   = cmd_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    step_d  = step_q;
    neg_d   = neg_q;
    ov_d    = ov_q && !pop;
    avg_d   = avg_q;
    hw_d    = hw_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = cmd_i;
          neg_d   = cmd_i.sum[SUM_BITS-1];
          mag_d   = cmd_i.sum[SUM_BITS-1] ? -cmd_i.sum : cmd_i.sum;
          rem_d   = '0;
          step_d  = '0;
        end
      end
      BK_DIV: begin
        rem_d  = fit ? trial - REM_BITS'(cmd_q.wsize) : trial;
        mag_d  = {mag_q[SUM_BITS-2:0], fit};
        step_d = step_q + 1'b1;
      end
      BK_MAIN: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          avg_d  = cmd_q.full_win ? quot[SAMPLE_BITS-1:0] : '0;
          hw_d   = cmd_q.full_win;
          last_d = cmd_q.eos && cmd_q.flush == '0;
        end
      end
      BK_FLUSH: begin
        if (slot_free) begin
          ov_d        = 1'b1;
          avg_d       = '0;
          hw_d        = 1'b0;
          last_d      = cmd_q.eos && cmd_q.flush == RAD_BITS'(1);
          cmd_d.flush = cmd_q.flush - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    avg_q  <= avg_d;
    hw_q   <= hw_d;
    last_q <= last_d;
  end

  assign empty         = !ov_q;
  assign average_o     = avg_q;
  assign has_window_o  = hw_q;
  assign last_result_o = last_q;

endmodule
`default_nettype wire

### design/centered_window_average.sv
// Centered moving average over a stream of signed samples with a radius k set through the
// configuration channel (window 2k+1, k up to 15); writing the radius restarts the stream.
// Each accepted sample is taken by the front part, which updates the sample ring and
// running sum and, when a result is due or the stream ends, queues a command in a
// two-entry queue. The back part loads a command, then turns it into results: an average
// whose window is full goes through a shared restoring divider, one quotient bit a cycle
// (load, divider steps, output); any other result skips the divider, and the final
// sample adds one result per flushed position. Input stalls only while the queue is full.
// Results leave through a one-word output register, read like a queue.
`default_nettype none
module centered_window_average (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cwa_pkg::RAD_BITS-1:0] radius_i,
  input  logic                         push,
  output logic                         full,
  input  cwa_pkg::sample_t             sample_i,
  input  logic                         end_of_stream_i,
  output logic                         empty,
  input  logic                         pop,
  output cwa_pkg::sample_t             average_o,
  output logic                         has_window_o,
  output logic                         last_result_o
);
  import cwa_pkg::*;

  logic cfg_take;
  logic take;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign full      = q_full;
  assign take      = push && !q_full;

  cwa_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i     (cfg_take),
    .cfg_radius_i    (radius_i),
    .take_i          (take),
    .sample_i,
    .end_of_stream_i,
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  cwa_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (cmd_out)
  );

  cwa_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i     (q_empty),
    .cmd_i         (cmd_out),
    .q_pop_o       (q_pop),
    .pop,
    .empty,
    .average_o,
    .has_window_o,
    .last_result_o
  );

endmodule
`default_nettype wire
